// File: rtl/core/masme_pkg.sv
`default_nettype none
package masme_pkg;

  localparam int RES_W   = 35;
  localparam int IN_W    = 16;
  localparam int DIM_W   = 4;
  localparam int CIDX_W  = 3;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_ROWS_A = 3'd1,
    REG_COLS_A = 3'd2,
    REG_ROWS_B = 3'd3,
    REG_COLS_B = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/masme_cell.sv
`default_nettype none
module masme_cell (
  input  wire logic                                clk,
  input  wire masme_pkg::cell_ctl_t                ctl,
  input  wire logic                                kill,
  input  wire logic signed [masme_pkg::RES_W-1:0]  d_in,
  input  wire logic signed [masme_pkg::RES_W-1:0]  addend,
  output logic signed [masme_pkg::RES_W-1:0]       acc
);

  logic signed [masme_pkg::RES_W-1:0] acc_r;
  logic signed [masme_pkg::RES_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = (kill ? '0 : d_in) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.shift) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// File: rtl/core/matrix_add_sub_mul_engine_top.sv
`default_nettype none
// matrix add / subtract / multiply engine
// input: a beat is taken when start is high and busy is low. each beat writes
// one element of matrix A or B at (row, col); a beat with load_done also starts
// the run chosen by the mode register. config: cfg_valid/cfg_ready write one
// register by index (0 mode, 1 rows_a, 2 cols_a, 3 rows_b, 4 cols_b), cfg_ready
// is always high; write only while busy is low.
// loads are taken one per cycle, back to back, while busy is low. a run emits
// the result matrix row by row on out_valid strobes, last on the final
// element. per result row a ring of MAX_DIM accumulator cells takes K passes
// of products (K = cols_a for the product, 1 for add/subtract), waits for the
// memory read and multiply pipeline to empty, then shifts the row out.
// a dimension error gives one error beat the cycle after the start beat; busy
// stays low. the receiver cannot stall: every out_valid beat is taken.
// after reset: mode add, all dimensions 1, stores hold nothing until loaded.
module matrix_add_sub_mul_engine_top #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_matrix_select,
  input  wire logic [2:0]                          in_row_pos,
  input  wire logic [2:0]                          in_col_pos,
  input  wire logic signed [15:0]                  in_element_value,
  input  wire logic                                in_load_done,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [masme_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [masme_pkg::DIM_W-1:0]         cfg_data,
  output logic                                     out_valid,
  output logic signed [masme_pkg::RES_W-1:0]       out_result_value,
  output logic [2:0]                               out_result_row,
  output logic [2:0]                               out_result_col,
  output logic                                     out_dimension_error,
  output logic                                     out_last
);

  localparam int RW     = masme_pkg::RES_W;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EW     = ELEMENT_WIDTH;
  localparam int XW     = (EW > masme_pkg::IN_W) ? EW : masme_pkg::IN_W;
  localparam int PW     = 2 * EW;
  localparam int PXW    = (PW > RW) ? PW : RW;
  localparam int DMW    = masme_pkg::DIM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT,
    ST_DRAIN
  } state_t;

  logic signed [EW-1:0] mem_a [DEPTH];
  logic signed [EW-1:0] mem_b [DEPTH];

  state_t             state_r;
  masme_pkg::mode_t   mode_r;
  logic [DMW-1:0]     rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [DW-1:0]      i_r, j_r, k_r;
  logic               rd_v_r, pr_v_r;
  logic signed [EW-1:0] rd_a_r, rd_b_r;
  logic signed [RW-1:0] op_r;
  logic               out_valid_r, out_err_r, out_last_r;
  logic signed [RW-1:0] out_val_r;
  logic [2:0]         out_row_r, out_col_r;

  logic               accept;
  logic               in_range;
  logic [AW-1:0]      wr_addr, ra_addr, rb_addr;
  logic signed [XW-1:0] in_ext;
  logic signed [EW-1:0] in_elem;
  logic [DMW-1:0]     nc, kmax;
  logic               dims_ok, run_ok;
  logic               last_j, last_k, last_i;
  logic signed [PW-1:0]  prod;
  logic signed [PXW-1:0] prod_ext;
  logic signed [RW-1:0]  op_nxt;

  masme_pkg::cell_ctl_t  ctl;
  logic signed [RW-1:0]  acc [MAX_DIM];
  logic signed [RW-1:0]  ring_in;
  logic                  ring_kill;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    in_ext   = XW'(in_element_value);
    in_elem  = in_ext[EW-1:0];
    in_range = (4'(in_row_pos) < 4'(MAX_DIM)) && (4'(in_col_pos) < 4'(MAX_DIM));
    wr_addr  = AW'(int'(in_row_pos) * MAX_DIM + int'(in_col_pos));
  end

  always_comb begin
    dims_ok = (rows_a_r != '0) && (rows_a_r <= DMW'(MAX_DIM)) &&
              (cols_a_r != '0) && (cols_a_r <= DMW'(MAX_DIM)) &&
              (rows_b_r != '0) && (rows_b_r <= DMW'(MAX_DIM)) &&
              (cols_b_r != '0) && (cols_b_r <= DMW'(MAX_DIM));
    unique case (mode_r)
      masme_pkg::MODE_ADD, masme_pkg::MODE_SUB: begin
        run_ok = dims_ok && (rows_a_r == rows_b_r) && (cols_a_r == cols_b_r);
        nc     = cols_a_r;
        kmax   = DMW'(1);
      end
      masme_pkg::MODE_MUL: begin
        run_ok = dims_ok && (cols_a_r == rows_b_r);
        nc     = cols_b_r;
        kmax   = cols_a_r;
      end
      default: begin
        run_ok = 1'b0;
        nc     = '0;
        kmax   = DMW'(1);
      end
    endcase
    last_j = (j_r == DW'(MAX_DIM - 1));
    last_k = (DMW'(k_r) == kmax - DMW'(1));
    last_i = (DMW'(i_r) + DMW'(1) == rows_a_r);
    if (mode_r == masme_pkg::MODE_MUL) begin
      ra_addr = AW'(int'(i_r) * MAX_DIM + int'(k_r));
      rb_addr = AW'(int'(k_r) * MAX_DIM + int'(j_r));
    end else begin
      ra_addr = AW'(int'(i_r) * MAX_DIM + int'(j_r));
      rb_addr = ra_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (in_matrix_select) begin
        mem_b[wr_addr] <= in_elem;
      end else begin
        mem_a[wr_addr] <= in_elem;
      end
    end
    rd_a_r <= mem_a[ra_addr];
    rd_b_r <= mem_b[rb_addr];
  end

  always_comb begin
    prod     = rd_a_r * rd_b_r;
    prod_ext = PXW'(prod);
    unique case (mode_r)
      masme_pkg::MODE_ADD: op_nxt = RW'(rd_a_r) + RW'(rd_b_r);
      masme_pkg::MODE_SUB: op_nxt = RW'(rd_a_r) - RW'(rd_b_r);
      default:             op_nxt = prod_ext[RW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  always_comb begin
    ctl.clr   = accept && in_load_done;
    ctl.shift = pr_v_r || (state_r == ST_DRAIN);
    ring_kill = (state_r == ST_DRAIN);
    ring_in   = acc[0];
  end

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    logic signed [RW-1:0] d_in;
    logic signed [RW-1:0] addend;
    logic                 kill;
    if (c == MAX_DIM - 1) begin : g_tail
      assign d_in   = ring_in;
      assign addend = ring_kill ? '0 : op_r;
      assign kill   = ring_kill;
    end else begin : g_body
      assign d_in   = acc[c+1];
      assign addend = '0;
      assign kill   = 1'b0;
    end
    masme_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .kill   (kill),
      .d_in   (d_in),
      .addend (addend),
      .acc    (acc[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= masme_pkg::MODE_ADD;
      rows_a_r    <= DMW'(1);
      cols_a_r    <= DMW'(1);
      rows_b_r    <= DMW'(1);
      cols_b_r    <= DMW'(1);
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      pr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_err_r   <= 1'b0;
      out_last_r  <= 1'b0;
      out_val_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
    end else begin
      rd_v_r      <= (state_r == ST_CALC);
      pr_v_r      <= rd_v_r;
      out_valid_r <= 1'b0;
      out_err_r   <= 1'b0;
      out_last_r  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          masme_pkg::REG_MODE:   mode_r   <= masme_pkg::mode_t'(cfg_data[1:0]);
          masme_pkg::REG_ROWS_A: rows_a_r <= cfg_data;
          masme_pkg::REG_COLS_A: cols_a_r <= cfg_data;
          masme_pkg::REG_ROWS_B: rows_b_r <= cfg_data;
          masme_pkg::REG_COLS_B: cols_b_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_load_done) begin
            if (run_ok) begin
              state_r <= ST_CALC;
              i_r     <= '0;
              j_r     <= '0;
              k_r     <= '0;
            end else begin
              out_valid_r <= 1'b1;
              out_err_r   <= 1'b1;
              out_last_r  <= 1'b1;
              out_val_r   <= '0;
              out_row_r   <= '0;
              out_col_r   <= '0;
            end
          end
        end
        ST_CALC: begin
          if (last_j) begin
            j_r <= '0;
            if (last_k) begin
              k_r     <= '0;
              state_r <= ST_WAIT;
            end else begin
              k_r <= k_r + DW'(1);
            end
          end else begin
            j_r <= j_r + DW'(1);
          end
        end
        ST_WAIT: begin
          if (!rd_v_r && !pr_v_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (DMW'(j_r) < nc) begin
            out_valid_r <= 1'b1;
            out_val_r   <= acc[0];
            out_row_r   <= 3'(i_r);
            out_col_r   <= 3'(j_r);
            out_last_r  <= last_i && (DMW'(j_r) + DMW'(1) == nc);
          end
          if (last_j) begin
            j_r <= '0;
            if (last_i) begin
              state_r <= ST_IDLE;
            end else begin
              i_r     <= i_r + DW'(1);
              state_r <= ST_CALC;
            end
          end else begin
            j_r <= j_r + DW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_val_r;
  assign out_result_row      = out_row_r;
  assign out_result_col      = out_col_r;
  assign out_dimension_error = out_err_r;
  assign out_last            = out_last_r;

endmodule
`default_nettype wire

// File: dv/tb_matrix_add_sub_mul_engine_top.sv
module tb_matrix_add_sub_mul_engine_top;

  localparam int LIMIT = 600000;

  typedef struct packed {
    logic [masme_pkg::RES_W-1:0] value;
    logic [2:0]       row;
    logic [2:0]       col;
    logic             err;
    logic             last;
  } elem_res_t;

  typedef struct {
    bit               is_cfg;
    masme_pkg::reg_idx_t idx;
    logic [3:0]       data;
    logic             sel;
    logic [2:0]       r;
    logic [2:0]       c;
    logic [15:0]      v;
    logic             done;
    bit               typed;
    logic [masme_pkg::RES_W-1:0] ev;
    logic             eerr;
  } plan_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_matrix_select = 0;
  logic [2:0] in_row_pos = 0;
  logic [2:0] in_col_pos = 0;
  logic signed [15:0] in_element_value = 0;
  logic in_load_done = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [masme_pkg::CIDX_W-1:0] cfg_index = 0;
  logic [masme_pkg::DIM_W-1:0] cfg_data = 0;
  logic out_valid;
  logic signed [masme_pkg::RES_W-1:0] out_result_value;
  logic [2:0] out_result_row;
  logic [2:0] out_result_col;
  logic out_dimension_error;
  logic out_last;

  matrix_add_sub_mul_engine_top DUT (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] mat_a [64];
  logic signed [15:0] mat_b [64];
  bit loaded_a [64];
  bit loaded_b [64];
  logic [1:0] op_mode;
  logic [3:0] dim_ra, dim_ca, dim_rb, dim_cb;

  elem_res_t pending_q [$];
  plan_row_t plan [$];
  int mismatches = 0;
  int cycles = 0;
  int items = 0;
  int idle_pct = 34;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_matrix_add_sub_mul_engine_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    elem_res_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_result_value, out_result_row, out_result_col, out_dimension_error, out_last};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  function automatic bit dim_fits(logic [3:0] d);
    return d >= 1 && d <= 8;
  endfunction

  function automatic void apply_load(logic sel, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                                     logic done, bit typed,
                                     logic [masme_pkg::RES_W-1:0] ev, logic eerr);
    bit ok;
    int nc;
    logic signed [masme_pkg::RES_W-1:0] acc;
    if (sel) begin
      mat_b[r*8+c] = v; loaded_b[r*8+c] = 1;
    end else begin
      mat_a[r*8+c] = v; loaded_a[r*8+c] = 1;
    end
    if (!done) return;
    if (typed) begin
      pending_q.push_back('{ev, 3'd0, 3'd0, eerr, 1'b1});
      return;
    end
    ok = dim_fits(dim_ra) && dim_fits(dim_ca) && dim_fits(dim_rb) && dim_fits(dim_cb);
    nc = 0;
    case (op_mode)
      masme_pkg::MODE_ADD, masme_pkg::MODE_SUB: begin
        ok = ok && dim_ra == dim_rb && dim_ca == dim_cb;
        nc = dim_ca;
      end
      masme_pkg::MODE_MUL: begin
        ok = ok && dim_ca == dim_rb;
        nc = dim_cb;
      end
      default: ok = 0;
    endcase
    if (!ok) begin
      pending_q.push_back('{'0, 3'd0, 3'd0, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < dim_ra; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        if (op_mode == masme_pkg::MODE_MUL) begin
          for (int k = 0; k < dim_ca; k++) acc += mat_a[i*8+k] * mat_b[k*8+j];
        end else if (op_mode == masme_pkg::MODE_ADD) begin
          acc = mat_a[i*8+j] + mat_b[i*8+j];
        end else begin
          acc = mat_a[i*8+j] - mat_b[i*8+j];
        end
        pending_q.push_back('{acc, i[2:0], j[2:0], 1'b0, (i == dim_ra - 1 && j == nc - 1)});
      end
    end
  endfunction

  task automatic write_reg(masme_pkg::reg_idx_t idx, logic [3:0] data);
    start <= 0;
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      masme_pkg::REG_MODE:   op_mode = data[1:0];
      masme_pkg::REG_ROWS_A: dim_ra = data;
      masme_pkg::REG_COLS_A: dim_ca = data;
      masme_pkg::REG_ROWS_B: dim_rb = data;
      masme_pkg::REG_COLS_B: dim_cb = data;
      default: ;
    endcase
    cfg_valid <= 0;
  endtask

  // returns in the step of the accepting edge with start still high
  task automatic send_load(logic sel, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                           logic done, bit typed, logic [masme_pkg::RES_W-1:0] ev,
                           logic eerr);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_matrix_select <= sel;
    in_row_pos <= r;
    in_col_pos <= c;
    in_element_value <= v;
    in_load_done <= done;
    do @(posedge clk); while (busy);
    apply_load(sel, r, c, v, done, typed, ev, eerr);
    items++;
  endtask

  function automatic void plan_cfg(masme_pkg::reg_idx_t idx, logic [3:0] data);
    plan_row_t p;
    p.is_cfg = 1; p.idx = idx; p.data = data;
    p.sel = 0; p.r = '0; p.c = '0; p.v = '0; p.done = 0;
    p.typed = 0; p.ev = '0; p.eerr = 0;
    plan.push_back(p);
  endfunction

  function automatic void plan_load(logic sel, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                                    logic done, bit typed,
                                    logic [masme_pkg::RES_W-1:0] ev, logic eerr);
    plan_row_t p;
    p.is_cfg = 0; p.idx = masme_pkg::REG_MODE; p.data = '0;
    p.sel = sel; p.r = r; p.c = c; p.v = v; p.done = done;
    p.typed = typed; p.ev = ev; p.eerr = eerr;
    plan.push_back(p);
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_dim();
    return ($urandom_range(9) == 0) ? 4'd8 : 4'($urandom_range(1, 3));
  endfunction

  task automatic random_run();
    logic [1:0] m;
    logic [3:0] ra, ca, rb, cb;
    int cells [$];
    int pick, t;
    m = 2'($urandom_range(2));
    ra = rand_dim(); ca = rand_dim();
    if (m == masme_pkg::MODE_MUL) begin
      rb = ca; cb = rand_dim();
    end else begin
      rb = ra; cb = ca;
    end
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: m = masme_pkg::MODE_RSV;
        1: ra = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(9, 15));
        2: cb = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(9, 15));
        default: rb = (rb == 4'd8) ? 4'd1 : rb + 4'd1;
      endcase
    end
    write_reg(masme_pkg::REG_MODE, {2'b00, m});
    write_reg(masme_pkg::REG_ROWS_A, ra);
    write_reg(masme_pkg::REG_COLS_A, ca);
    write_reg(masme_pkg::REG_ROWS_B, rb);
    write_reg(masme_pkg::REG_COLS_B, cb);
    // every cell that the run reads is loaded if it holds no data yet; most others are loaded again
    if (dim_fits(ra) && dim_fits(ca))
      for (int i = 0; i < ra; i++)
        for (int j = 0; j < ca; j++)
          if (!loaded_a[i*8+j] || $urandom_range(4) != 0) cells.push_back(i*8+j);
    if (dim_fits(rb) && dim_fits(cb))
      for (int i = 0; i < rb; i++)
        for (int j = 0; j < cb; j++)
          if (!loaded_b[i*8+j] || $urandom_range(4) != 0) cells.push_back(64 + i*8+j);
    for (int i = cells.size() - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      t = cells[i]; cells[i] = cells[pick]; cells[pick] = t;
    end
    foreach (cells[i]) begin
      if ($urandom_range(9) == 0)
        send_load(1'($urandom), 3'($urandom), 3'($urandom), rand_elem(), 0, 0, '0, 0);
      send_load(cells[i] >= 64, 3'((cells[i] % 64) / 8), 3'(cells[i] % 8), rand_elem(), 0,
                0, '0, 0);
    end
    if (cells.size() > 0) begin
      t = cells[cells.size() - 1];
      send_load(t >= 64, 3'((t % 64) / 8), 3'(t % 8), rand_elem(), 1, 0, '0, 0);
    end else begin
      send_load(0, 3'd0, 3'd0, rand_elem(), 1, 0, '0, 0);
    end
  endtask

  initial begin
    op_mode = masme_pkg::MODE_ADD;
    dim_ra = 1; dim_ca = 1; dim_rb = 1; dim_cb = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    plan_load(0, 3'd0, 3'd0, 16'h8000, 0, 0, '0, 0);
    plan_load(1, 3'd0, 3'd0, 16'h8000, 1, 1, -35'sd65536, 0);
    plan_cfg(masme_pkg::REG_MODE, {2'b00, masme_pkg::MODE_SUB});
    plan_load(1, 3'd0, 3'd0, 16'h7fff, 1, 1, -35'sd65535, 0);
    plan_cfg(masme_pkg::REG_MODE, {2'b00, masme_pkg::MODE_MUL});
    plan_load(0, 3'd0, 3'd0, 16'h8000, 1, 1, -35'sd1073709056, 0);
    plan_load(1, 3'd0, 3'd0, 16'h8000, 1, 1, 35'sd1073741824, 0);
    plan_cfg(masme_pkg::REG_MODE, {2'b00, masme_pkg::MODE_RSV});
    plan_load(0, 3'd7, 3'd7, 16'h5555, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_MODE, {2'b00, masme_pkg::MODE_ADD});
    plan_cfg(masme_pkg::REG_ROWS_A, 4'd0);
    plan_load(1, 3'd7, 3'd7, 16'haaaa, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_ROWS_A, 4'd15);
    plan_load(0, 3'd3, 3'd4, 16'h0000, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_ROWS_A, 4'd2);
    plan_load(1, 3'd5, 3'd2, 16'h0001, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_MODE, {2'b00, masme_pkg::MODE_MUL});
    plan_cfg(masme_pkg::REG_ROWS_A, 4'd1);
    plan_cfg(masme_pkg::REG_COLS_A, 4'd2);
    plan_load(0, 3'd6, 3'd1, 16'h1234, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_COLS_A, 4'd1);
    plan_cfg(masme_pkg::REG_ROWS_A, 4'd2);
    plan_cfg(masme_pkg::REG_COLS_B, 4'd0);
    plan_load(0, 3'd1, 3'd0, 16'h1234, 1, 1, '0, 1);
    plan_cfg(masme_pkg::REG_COLS_B, 4'd1);
    plan_cfg(masme_pkg::REG_ROWS_B, 4'd1);
    plan_load(0, 3'd0, 3'd0, 16'hffff, 0, 0, '0, 0);
    plan_load(1, 3'd0, 3'd0, 16'h7fff, 1, 0, '0, 0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_load(plan[i].sel, plan[i].r, plan[i].c, plan[i].v, plan[i].done,
                     plan[i].typed, plan[i].ev, plan[i].eerr);
    end

    items = 0;
    while (items < 170) begin
      if (items >= 114) idle_pct = 0;
      else if (items >= 57) idle_pct = 52;
      random_run();
    end
    start <= 0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("tb_matrix_add_sub_mul_engine_top: done, clean");
    else $display("tb_matrix_add_sub_mul_engine_top: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/masme_pkg.sv
rtl/core/masme_cell.sv
rtl/core/matrix_add_sub_mul_engine_top.sv
dv/tb_matrix_add_sub_mul_engine_top.sv
